// File: hw/rtl/cube_distance_one_check_defines.svh
// assertion macros for the cube distance-one checker
// no dependencies; included by cdoc_accum, the module that checks its own logic
`ifndef CUBE_DISTANCE_ONE_CHECK_DEFINES_SVH
`define CUBE_DISTANCE_ONE_CHECK_DEFINES_SVH

`ifndef SYNTHESIS
`define CDOC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("cdoc assertion failed");
`define CDOC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cdoc assertion failed");
`else
`define CDOC_ASSERT(lbl, clk, rstn, prop)
`define CDOC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: hw/rtl/cdoc_pkg.sv
// shared types, constants and functions of the cube distance-one checker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cdoc_pkg;

  localparam int unsigned WordW         = 32;
  localparam int unsigned VarsPerWord   = 16;
  localparam int unsigned LaneIdxW      = 4;
  localparam int unsigned VarIdxW       = 8;
  localparam int unsigned TotalW        = 2;
  localparam int unsigned MaxWordsDflt  = 16;
  localparam logic [WordW-1:0] PairLowBits = 32'h5555_5555;
  localparam logic [WordW-1:0] MaskReset   = 32'h5555_5555;
  localparam logic [TotalW-1:0] TotalSat   = 2'd2;

  typedef struct packed {
    logic [WordW-1:0] word_a;
    logic [WordW-1:0] word_b;
    logic             final_word;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [VarIdxW-1:0] variable_index;
  } out_item_t;

  // one bit per unmasked variable: set where the two cubes differ in both bits (01/10 or 00/11)
  function automatic logic [VarsPerWord-1:0] conflict_lanes(
    input logic [WordW-1:0] a,
    input logic [WordW-1:0] b,
    input logic [WordW-1:0] mask
  );
    logic [WordW-1:0]       x;
    logic [VarsPerWord-1:0] lanes;
    x = a ^ b;
    x = (x >> 1) & x & mask;
    for (int i = 0; i < VarsPerWord; i++) begin
      lanes[i] = x[2*i];
    end
    return lanes;
  endfunction

  // highest set lane
  function automatic logic [LaneIdxW-1:0] last_lane(input logic [VarsPerWord-1:0] lanes);
    logic [LaneIdxW-1:0] idx;
    idx = '0;
    for (int i = 0; i < VarsPerWord; i++) begin
      if (lanes[i]) begin
        idx = LaneIdxW'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/cube_distance_one_check.sv
// top level of the cube distance-one checker
// depends on cdoc_pkg, cdoc_in_stage, cdoc_accum, cdoc_out_reg
//
// channel   signals                              carries
// in        in_valid_i / in_ready_o / in_item_i  word pair of two cubes, final marker
// out       out_valid_o / out_ready_i / out_item_o  found flag and variable index
// cfg       cfg_we_i / cfg_wdata_i               last word mask, write only
//
// one item per cycle while final items find output room; every item passes the
// input register; a final item's result is then written to the output register
// per-cube state is a word counter, a two-bit conflict count and an index
// reset clears the valid flags, counters and index and loads the mask with 0x55555555
// a stalled result holds back only final items; others flow unless behind a held final item
`timescale 1ns / 1ps
`default_nettype none

module cube_distance_one_check #(
  parameter int unsigned MAX_WORDS = cdoc_pkg::MaxWordsDflt
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [31:0]         cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire cdoc_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output cdoc_pkg::out_item_t      out_item_o
);

  logic                s1_valid;
  cdoc_pkg::in_item_t  s1_item;
  logic                take;
  logic                out_free;
  logic                res_valid;
  cdoc_pkg::out_item_t res_item;

  cdoc_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .take_i     (take),
    .s1_valid_o (s1_valid),
    .s1_item_o  (s1_item)
  );

  cdoc_accum #(
    .MAX_WORDS (MAX_WORDS)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s1_valid_i  (s1_valid),
    .s1_item_i   (s1_item),
    .out_free_i  (out_free),
    .take_o      (take),
    .res_valid_o (res_valid),
    .res_item_o  (res_item)
  );

  cdoc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_item_i  (res_item),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/cdoc_in_stage.sv
// input register of the cube distance-one checker
// depends on cdoc_pkg
`timescale 1ns / 1ps
`default_nettype none

module cdoc_in_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire cdoc_pkg::in_item_t in_item_i,
  input  wire logic              take_i,
  output logic                   s1_valid_o,
  output cdoc_pkg::in_item_t     s1_item_o
);

  logic               s1_valid_q, s1_valid_d;
  cdoc_pkg::in_item_t s1_item_q;

  assign in_ready_o = !s1_valid_q || take_i;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_valid_i && in_ready_o) begin
      s1_valid_d = 1'b1;
    end else if (take_i) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= in_item_i;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_item_o  = s1_item_q;

endmodule

`default_nettype wire

// File: hw/rtl/cdoc_accum.sv
// conflict detection and per-cube state of the cube distance-one checker
// depends on cdoc_pkg and cube_distance_one_check_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "cube_distance_one_check_defines.svh"

module cdoc_accum #(
  parameter int unsigned MAX_WORDS = cdoc_pkg::MaxWordsDflt
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [31:0]        cfg_wdata_i,
  input  wire logic               s1_valid_i,
  input  wire cdoc_pkg::in_item_t s1_item_i,
  input  wire logic               out_free_i,
  output logic                    take_o,
  output logic                    res_valid_o,
  output cdoc_pkg::out_item_t     res_item_o
);

  localparam int unsigned PosW = $clog2(MAX_WORDS + 1);
  localparam logic [PosW-1:0] PosMax = PosW'(MAX_WORDS);

  logic [cdoc_pkg::WordW-1:0]       mask_q;
  logic [PosW-1:0]                  pos_q, pos_d;
  logic [cdoc_pkg::TotalW-1:0]      total_q, total_d, total_upd;
  logic [cdoc_pkg::VarIdxW-1:0]     var_q, var_d, var_upd;
  logic                             active;
  logic [cdoc_pkg::WordW-1:0]       lane_mask;
  logic [cdoc_pkg::VarsPerWord-1:0] lanes;
  logic                             hit_any, hit_multi;
  logic [cdoc_pkg::TotalW:0]        sum;
  logic [cdoc_pkg::LaneIdxW-1:0]    pos_lo;

  assign active    = pos_q < PosMax;
  assign lane_mask = s1_item_i.final_word ? (mask_q & cdoc_pkg::PairLowBits)
                                          : cdoc_pkg::PairLowBits;
  assign lanes     = cdoc_pkg::conflict_lanes(s1_item_i.word_a, s1_item_i.word_b, lane_mask);
  assign hit_any   = active && (|lanes);
  assign hit_multi = |(lanes & (lanes - cdoc_pkg::VarsPerWord'(1)));
  assign pos_lo    = cdoc_pkg::LaneIdxW'(pos_q);

  always_comb begin
    sum = {1'b0, total_q};
    if (hit_any) begin
      sum = {1'b0, total_q} + (hit_multi ? 3'd2 : 3'd1);
    end
    total_upd = (sum > {1'b0, cdoc_pkg::TotalSat}) ? cdoc_pkg::TotalSat
                                                   : sum[cdoc_pkg::TotalW-1:0];
    var_upd = hit_any ? {pos_lo, cdoc_pkg::last_lane(lanes)} : var_q;
  end

  // a final item needs room in the output register
  assign take_o      = s1_valid_i && (!s1_item_i.final_word || out_free_i);
  assign res_valid_o = take_o && s1_item_i.final_word;

  always_comb begin
    res_item_o.found          = (total_upd == 2'd1);
    res_item_o.variable_index = res_item_o.found ? var_upd : '0;
  end

  always_comb begin
    pos_d   = pos_q;
    total_d = total_q;
    var_d   = var_q;
    if (take_o) begin
      if (s1_item_i.final_word) begin
        pos_d   = '0;
        total_d = '0;
        var_d   = '0;
      end else begin
        pos_d   = active ? pos_q + PosW'(1) : pos_q;
        total_d = total_upd;
        var_d   = var_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= cdoc_pkg::MaskReset;
      pos_q   <= '0;
      total_q <= '0;
      var_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        mask_q <= cfg_wdata_i;
      end
      pos_q   <= pos_d;
      total_q <= total_d;
      var_q   <= var_d;
    end
  end

  `CDOC_ASSERT(a_pos_bound, clk_i, rst_ni, pos_q <= PosMax)
  `CDOC_ASSERT(a_total_sat, clk_i, rst_ni, total_q <= cdoc_pkg::TotalSat)
  `CDOC_ASSERT(a_clear_after_final, clk_i, rst_ni, res_valid_o |=> ({pos_q, total_q, var_q} == '0))
  `CDOC_ASSERT(a_no_result_unfree, clk_i, rst_ni, res_valid_o |-> out_free_i)

endmodule

`default_nettype wire

// File: hw/rtl/cdoc_out_reg.sv
// result register of the cube distance-one checker
// depends on cdoc_pkg
`timescale 1ns / 1ps
`default_nettype none

module cdoc_out_reg (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                res_valid_i,
  input  wire cdoc_pkg::out_item_t res_item_i,
  output logic                     out_free_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output cdoc_pkg::out_item_t      out_item_o
);

  logic                out_valid_q, out_valid_d;
  cdoc_pkg::out_item_t out_item_q;

  assign out_free_o = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid_i) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      out_item_q <= res_item_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire
